// ===== src/stwa_pkg.sv =====
// Shared types and constants of the subscriber table with aging.
// Request, response and table entry layouts, command codes and controller states.
// No dependencies.
package stwa_pkg;

	localparam int TTL_W    = 17;
	localparam int TTL_MS_W = 27;
	localparam int EXP_W    = 32;

	localparam logic [9:0]          MS_PER_SECOND = 10'd1000;
	localparam logic [TTL_MS_W-1:0] TTL_MS_RESET  = 27'd60000;

	localparam logic [1:0] CMD_SUBSCRIBE   = 2'd0;
	localparam logic [1:0] CMD_UNSUBSCRIBE = 2'd1;
	localparam logic [1:0] CMD_PING        = 2'd2;
	localparam logic [1:0] CMD_PUBLISH     = 2'd3;

	localparam logic [1:0] KIND_SUBSCRIBED = 2'd0;
	localparam logic [1:0] KIND_PONG       = 2'd1;
	localparam logic [1:0] KIND_LISTED     = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  addr_type;
		logic [31:0] ip_address;
		logic [15:0] port_number;
		logic [30:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [2:0]  out_type;
		logic [31:0] out_ip;
		logic [15:0] out_port;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [2:0]       addr_type;
		logic [31:0]      ip_address;
		logic [15:0]      port_number;
		logic [EXP_W-1:0] expiry;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic remove;
		logic insert;
	} order_op_t;

	typedef struct packed {
		logic load_hold;
		logic flush_hold;
		logic reply;
	} emit_ctl_t;

	typedef struct packed {
		logic hold_valid;
		logic out_free;
	} emit_sts_t;

endpackage

// ===== src/stwa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds while the read enable is low. No dependencies.
module stwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/stwa_order.sv =====
// Order list of the subscriber table: a permutation of the physical entry slots.
// Positions below the live count hold live entries, newest first. Uses stwa_pkg.
module stwa_order
	import stwa_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  order_op_t                                    op,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] pos,
	input  logic [$clog2(DEPTH + 1)-1:0]                 count,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] tail,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_pos,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_phys
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [IW-1:0] order_q [DEPTH];

	assign rd_phys = order_q[rd_pos];

	// An insertion expects rd_pos to equal count, so rd_phys is the free slot taken.
	for (genvar j = 0; j < DEPTH; j++) begin : g_slot
		localparam logic [CW-1:0] JC = CW'(j);
		logic [IW-1:0] up_val;
		logic [IW-1:0] dn_val;

		if (j == DEPTH - 1) begin : g_tail
			assign up_val = tail;
		end else begin : g_mid
			assign up_val = order_q[j + 1];
		end

		if (j == 0) begin : g_head
			assign dn_val = rd_phys;
		end else begin : g_rest
			assign dn_val = order_q[j - 1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				order_q[j] <= IW'(j);
			end else if (op.remove && (JC >= CW'(pos))) begin
				order_q[j] <= up_val;
			end else if (op.insert && (JC <= count)) begin
				order_q[j] <= dn_val;
			end
		end
	end

endmodule

// ===== src/stwa_emit.sv =====
// Response stage: output register plus a one-entry hold buffer for list replies.
// The hold buffer lets the final listed entry carry the last mark. Uses stwa_pkg.
module stwa_emit
	import stwa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  emit_ctl_t ctl,
	input  entry_t    entry,
	input  rsp_t      reply,
	output emit_sts_t sts,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_t      rsp
);

	logic rsp_valid_q;
	logic hold_valid_q;
	rsp_t rsp_q;
	rsp_t hold_q;
	rsp_t listed;
	rsp_t flushed;

	always_comb begin
		listed            = '0;
		listed.reply_kind = KIND_LISTED;
		listed.out_type   = entry.addr_type;
		listed.out_ip     = entry.ip_address;
		listed.out_port   = entry.port_number;
		listed.last       = 1'b0;
		flushed           = hold_q;
		flushed.last      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (ctl.load_hold) begin
				hold_valid_q <= 1'b1;
			end else if (ctl.flush_hold) begin
				hold_valid_q <= 1'b0;
			end
			if ((ctl.load_hold && hold_valid_q) || ctl.flush_hold || ctl.reply) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_hold) begin
			hold_q <= listed;
			if (hold_valid_q) begin
				rsp_q <= hold_q;
			end
		end
		if (ctl.flush_hold) begin
			rsp_q <= flushed;
		end
		if (ctl.reply) begin
			rsp_q <= reply;
		end
	end

	assign sts.hold_valid = hold_valid_q;
	assign sts.out_free   = !rsp_valid_q || rsp_ready;
	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;

endmodule

// ===== src/subscriber_table_with_aging_core.sv =====
// Top level of the subscriber table with aging: controller, entry memory and order list.
// Depends on stwa_pkg, stwa_ram, stwa_order and stwa_emit.
//
// Each request walks the live entries in order, newest first, reading one entry per cycle
// from the entry memory unless the walk stalls. The block takes no new request until it
// is through with the last one. The walk stalls while a list request has a listed entry
// held and finds the response register full and not being taken, and every request waits
// in its finish state until the response register is free.
// The walk prunes expired entries for subscribe and publish requests, removes or refreshes
// a matching entry and queues list replies; the finish state inserts a new entry and
// issues any reply. The table is empty after reset and needs no clearing pass. The
// time-to-live register may be written at any time the block holds no request.
module subscriber_table_with_aging_core
	import stwa_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TTL_W-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

	state_t               state_q;
	state_t               state_d;
	logic [CW-1:0]        n_q;
	logic [IW-1:0]        p_q;
	logic [CW-1:0]        rem_q;
	logic                 found_q;
	logic [TTL_MS_W-1:0]  ttl_ms_q;
	req_t                 req_q;
	logic [EXP_W-1:0]     exp_q;
	logic [IW-1:0]        phys_s1;

	logic                 accept;
	logic                 is_sub;
	logic                 is_unsub;
	logic                 is_ping;
	logic                 is_pub;
	logic                 expired;
	logic                 hit;
	logic                 remove;
	logic                 refresh;
	logic                 pub_push;
	logic                 stall;
	logic                 step;
	logic                 last_ent;
	logic                 fin_go;
	logic                 room;
	logic                 do_insert;
	logic [EXP_W:0]       exp_sum;
	logic [EXP_W-1:0]     exp_new;
	logic [CW-1:0]        p_next;

	logic                 rd_en;
	logic [IW-1:0]        rd_pos;
	logic [IW-1:0]        rd_phys;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	entry_t               wr_data;
	entry_t               ent;
	logic [ENTRY_W-1:0]   ent_bits;
	order_op_t            order_op;
	emit_ctl_t            emit_ctl;
	emit_sts_t            emit_sts;
	rsp_t                 reply;

	assign accept   = req_valid && req_ready;
	assign is_sub   = (req_q.command == CMD_SUBSCRIBE);
	assign is_unsub = (req_q.command == CMD_UNSUBSCRIBE);
	assign is_ping  = (req_q.command == CMD_PING);
	assign is_pub   = (req_q.command == CMD_PUBLISH);

	assign ent      = entry_t'(ent_bits);
	assign expired  = ent.expiry < {1'b0, req_q.now_ms};
	assign hit      = (ent.addr_type == req_q.addr_type) &&
	                  (ent.ip_address == req_q.ip_address) &&
	                  (ent.port_number == req_q.port_number);
	assign remove   = ((is_sub || is_pub) && expired) || (is_unsub && hit);
	assign refresh  = (is_sub && hit && !expired) || (is_ping && hit);
	assign pub_push = is_pub && !expired;
	assign stall    = pub_push && emit_sts.hold_valid && !emit_sts.out_free;
	assign step     = (state_q == ST_SCAN) && !stall;
	assign last_ent = (rem_q == CW'(1));
	assign p_next   = CW'(p_q) + CW'(1);

	assign fin_go    = (state_q == ST_FINISH) && emit_sts.out_free;
	assign room      = (n_q != FULL_COUNT);
	assign do_insert = fin_go && is_sub && !found_q && room;

	assign exp_sum = {1'b0, 1'b0, req.now_ms} + (EXP_W + 1)'(ttl_ms_q);
	assign exp_new = exp_sum[EXP_W] ? {EXP_W{1'b1}} : exp_sum[EXP_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (n_q != '0) ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (step && last_ent) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (emit_sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready           = 1'b0;
		rd_en               = 1'b0;
		rd_pos              = '0;
		wr_en               = 1'b0;
		wr_addr             = phys_s1;
		wr_data.addr_type   = req_q.addr_type;
		wr_data.ip_address  = req_q.ip_address;
		wr_data.port_number = req_q.port_number;
		wr_data.expiry      = exp_q;
		order_op            = '0;
		emit_ctl            = '0;
		reply.reply_kind    = is_ping ? KIND_PONG : KIND_SUBSCRIBED;
		reply.out_type      = req_q.addr_type;
		reply.out_ip        = req_q.ip_address;
		reply.out_port      = req_q.port_number;
		reply.last          = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				rd_en     = accept && (n_q != '0);
			end
			ST_SCAN: begin
				rd_pos = p_next[IW-1:0];
				if (step) begin
					rd_en              = !last_ent;
					wr_en              = refresh;
					order_op.remove    = remove;
					emit_ctl.load_hold = pub_push;
				end
			end
			ST_FINISH: begin
				rd_pos              = n_q[IW-1:0];
				wr_addr             = rd_phys;
				wr_en               = do_insert;
				order_op.insert     = do_insert;
				emit_ctl.reply      = fin_go && ((is_sub && (found_q || room)) || is_ping);
				emit_ctl.flush_hold = fin_go && is_pub && emit_sts.hold_valid;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			p_q      <= '0;
			rem_q    <= '0;
			found_q  <= 1'b0;
			ttl_ms_q <= TTL_MS_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				ttl_ms_q <= TTL_MS_W'(cfg_wdata) * TTL_MS_W'(MS_PER_SECOND);
			end
			if (accept) begin
				p_q     <= '0;
				rem_q   <= n_q;
				found_q <= 1'b0;
			end else if (step) begin
				rem_q <= rem_q - CW'(1);
				if (!remove) begin
					p_q <= p_next[IW-1:0];
				end
				if (remove) begin
					n_q <= n_q - CW'(1);
				end
				if (is_sub && refresh) begin
					found_q <= 1'b1;
				end
			end else if (do_insert) begin
				n_q <= n_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			exp_q <= exp_new;
		end
		if (rd_en) begin
			phys_s1 <= rd_phys;
		end
	end

	stwa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_phys),
		.rdata (ent_bits)
	);

	stwa_order #(
		.DEPTH(TABLE_DEPTH)
	) u_order (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (order_op),
		.pos     (p_q),
		.count   (n_q),
		.tail    (phys_s1),
		.rd_pos  (rd_pos),
		.rd_phys (rd_phys)
	);

	stwa_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (emit_ctl),
		.entry     (ent),
		.reply     (reply),
		.sts       (emit_sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// The live count never exceeds the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= FULL_COUNT)
		else $error("live count above table depth");

	// The walk never runs with no entries left to visit.
	a_scan_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rem_q != '0))
		else $error("scan with no entries remaining");

	// A removal during the walk drops the live count by exactly one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(step && remove) |=> (n_q == $past(n_q) - CW'(1)))
		else $error("removal did not decrement live count");

	// No list entry is left pending once the block is idle again.
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !emit_sts.hold_valid)
		else $error("list entry pending while idle");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the subscriber table with aging.
// Directed table then random phases over several lifetimes, checked against an in-bench table model.
// Depends on stwa_pkg and subscriber_table_with_aging_core.
`timescale 1ns / 1ps

module tb;
	import stwa_pkg::*;

	localparam int DEPTH       = 16;
	localparam int LIMIT       = 200000;
	localparam int SETTLE      = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int POOL        = 20;
	localparam int PHASE_ITEMS = 50;

	typedef struct packed {
		logic [2:0]  addr_type;
		logic [31:0] ip;
		logic [15:0] port;
	} peer_t;

	typedef struct packed {
		req_t rq;
		logic typed;
		rsp_t want;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [TTL_W-1:0] cfg_wdata = '0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;

	subscriber_table_with_aging_core #(.TABLE_DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// Table model: live entries occupy 0..live_n-1, newest first.
	logic [2:0]       tbl_type [DEPTH];
	logic [31:0]      tbl_ip   [DEPTH];
	logic [15:0]      tbl_port [DEPTH];
	logic [31:0]      tbl_exp  [DEPTH];
	int               live_n = 0;
	logic [TTL_W-1:0] ttl_s = 17'd60;

	rsp_t     fresh_q[$];
	rsp_t     reply_q[$];
	dir_row_t dir_tab[$];
	peer_t    pool[POOL];
	logic [30:0] now_cur;

	int errors = 0;
	int cyc = 0;
	bit steady = 1'b0;
	bit hold_go = 1'b0;

	function automatic req_t req_of(logic [1:0] cmd, logic [2:0] t, logic [31:0] ip,
			logic [15:0] port, logic [30:0] now);
		req_t r;
		r.command     = cmd;
		r.addr_type   = t;
		r.ip_address  = ip;
		r.port_number = port;
		r.now_ms      = now;
		return r;
	endfunction

	function automatic rsp_t rsp_of(logic [1:0] kind, logic [2:0] t, logic [31:0] ip,
			logic [15:0] port, logic last);
		rsp_t r;
		r.reply_kind = kind;
		r.out_type   = t;
		r.out_ip     = ip;
		r.out_port   = port;
		r.last       = last;
		return r;
	endfunction

	function automatic logic [31:0] expiry_for(logic [30:0] now);
		logic [33:0] sum;
		sum = {3'b000, now} + ttl_s * 34'd1000;
		if (sum > 34'h0_FFFF_FFFF) begin
			return 32'hFFFF_FFFF;
		end
		return sum[31:0];
	endfunction

	function automatic int find_entry(req_t r);
		int i;
		for (i = 0; i < live_n; i++) begin
			if (tbl_type[i] == r.addr_type && tbl_ip[i] == r.ip_address &&
					tbl_port[i] == r.port_number) begin
				return i;
			end
		end
		return -1;
	endfunction

	task automatic drop_at(int pos);
		int i;
		for (i = pos; i + 1 < live_n; i++) begin
			tbl_type[i] = tbl_type[i + 1];
			tbl_ip[i]   = tbl_ip[i + 1];
			tbl_port[i] = tbl_port[i + 1];
			tbl_exp[i]  = tbl_exp[i + 1];
		end
		live_n--;
	endtask

	task automatic prune_table(logic [30:0] now);
		int i;
		i = 0;
		while (i < live_n) begin
			if (tbl_exp[i] < {1'b0, now}) begin
				drop_at(i);
			end else begin
				i++;
			end
		end
	endtask

	task automatic model_request(req_t r);
		int pos;
		int i;
		case (r.command)
			CMD_SUBSCRIBE: begin
				prune_table(r.now_ms);
				pos = find_entry(r);
				if (pos >= 0) begin
					tbl_exp[pos] = expiry_for(r.now_ms);
				end else if (live_n < DEPTH) begin
					for (i = live_n; i > 0; i--) begin
						tbl_type[i] = tbl_type[i - 1];
						tbl_ip[i]   = tbl_ip[i - 1];
						tbl_port[i] = tbl_port[i - 1];
						tbl_exp[i]  = tbl_exp[i - 1];
					end
					tbl_type[0] = r.addr_type;
					tbl_ip[0]   = r.ip_address;
					tbl_port[0] = r.port_number;
					tbl_exp[0]  = expiry_for(r.now_ms);
					live_n++;
				end else begin
					return;
				end
				fresh_q.push_back(rsp_of(KIND_SUBSCRIBED, r.addr_type, r.ip_address,
					r.port_number, 1'b1));
			end
			CMD_UNSUBSCRIBE: begin
				pos = find_entry(r);
				if (pos >= 0) begin
					drop_at(pos);
				end
			end
			CMD_PING: begin
				pos = find_entry(r);
				if (pos >= 0) begin
					tbl_exp[pos] = expiry_for(r.now_ms);
				end
				fresh_q.push_back(rsp_of(KIND_PONG, r.addr_type, r.ip_address,
					r.port_number, 1'b1));
			end
			default: begin
				prune_table(r.now_ms);
				for (i = 0; i < live_n; i++) begin
					fresh_q.push_back(rsp_of(KIND_LISTED, tbl_type[i], tbl_ip[i], tbl_port[i],
						i == live_n - 1));
				end
			end
		endcase
	endtask

	task automatic offer(req_t r, logic typed, rsp_t want);
		int i;
		if (!steady) begin
			while ($urandom_range(99) < 21) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		fresh_q.delete();
		model_request(r);
		if (typed) begin
			reply_q.push_back(want);
		end else begin
			for (i = 0; i < fresh_q.size(); i++) begin
				reply_q.push_back(fresh_q[i]);
			end
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (reply_q.size() != 0);
	endtask

	task automatic write_ttl(logic [TTL_W-1:0] v);
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		ttl_s = v;
	endtask

	function automatic req_t roll_request(int step);
		req_t r;
		int c;
		int p;
		c = $urandom_range(99);
		if (c < 45) begin
			r.command = CMD_SUBSCRIBE;
		end else if (c < 60) begin
			r.command = CMD_UNSUBSCRIBE;
		end else if (c < 75) begin
			r.command = CMD_PING;
		end else begin
			r.command = CMD_PUBLISH;
		end
		if ($urandom_range(9) == 0) begin
			r.addr_type   = 3'($urandom);
			r.ip_address  = $urandom;
			r.port_number = 16'($urandom);
		end else begin
			p = $urandom_range(POOL - 1);
			r.addr_type   = pool[p].addr_type;
			r.ip_address  = pool[p].ip;
			r.port_number = pool[p].port;
		end
		if ($urandom_range(9) == 0) begin
			r.now_ms = 31'($urandom);
		end else begin
			now_cur  = now_cur + 31'($urandom_range(step));
			r.now_ms = now_cur;
		end
		return r;
	endfunction

	task automatic run_random(int n, int step, int phase);
		int i;
		now_cur = 31'($urandom);
		for (i = 0; i < n; i++) begin
			if (phase == 1 && i == 0) steady = 1'b1;
			if (phase == 1 && i == 40) steady = 1'b0;
			if (phase == 1 && i == 20) hold_go <= 1'b1;
			if (phase == 2 && i == 30) drain();
			offer(roll_request(step), 1'b0, '0);
		end
	endtask

	task automatic flag(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Response side: check each accepted response and drive rsp_ready.
	int hold_left = 0;
	bit hold_done = 1'b0;
	rsp_t want_r;

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (reply_q.size() == 0) begin
				$display("%0t: unexpected response, expected none, got kind %0h ip %0h port %0h",
					$time, rsp.reply_kind, rsp.out_ip, rsp.out_port);
				errors++;
			end else begin
				want_r = reply_q.pop_front();
				flag("reply_kind", 32'(want_r.reply_kind), 32'(rsp.reply_kind));
				flag("out_type", 32'(want_r.out_type), 32'(rsp.out_type));
				flag("out_ip", want_r.out_ip, rsp.out_ip);
				flag("out_port", 32'(want_r.out_port), 32'(rsp.out_port));
				flag("last", 32'(want_r.last), 32'(rsp.last));
			end
		end
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= steady || ($urandom_range(99) >= 21);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int i;
		dir_tab.push_back('{req_of(CMD_PUBLISH, 3'd0, 32'h0, 16'h0, 31'd0), 1'b0, '0});
		dir_tab.push_back('{req_of(CMD_SUBSCRIBE, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 31'd0), 1'b1,
			rsp_of(KIND_SUBSCRIBED, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1)});
		dir_tab.push_back('{req_of(CMD_SUBSCRIBE, 3'd0, 32'h0, 16'h0, 31'd0), 1'b1,
			rsp_of(KIND_SUBSCRIBED, 3'd0, 32'h0, 16'h0, 1'b1)});
		dir_tab.push_back('{req_of(CMD_PING, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 31'd1000), 1'b1,
			rsp_of(KIND_PONG, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1)});
		dir_tab.push_back('{req_of(CMD_PING, 3'd3, 32'h0A00_0001, 16'h1234, 31'd1000), 1'b1,
			rsp_of(KIND_PONG, 3'd3, 32'h0A00_0001, 16'h1234, 1'b1)});
		dir_tab.push_back('{req_of(CMD_UNSUBSCRIBE, 3'd3, 32'h0A00_0001, 16'h1234, 31'd1000),
			1'b0, '0});
		dir_tab.push_back('{req_of(CMD_PUBLISH, 3'd0, 32'h0, 16'h0, 31'd60000), 1'b0, '0});
		dir_tab.push_back('{req_of(CMD_PUBLISH, 3'd0, 32'h0, 16'h0, 31'd60001), 1'b0, '0});
		dir_tab.push_back('{req_of(CMD_PING, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 31'd70000), 1'b1,
			rsp_of(KIND_PONG, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1)});
		dir_tab.push_back('{req_of(CMD_PUBLISH, 3'd0, 32'h0, 16'h0, 31'd130000), 1'b0, '0});
		dir_tab.push_back('{req_of(CMD_SUBSCRIBE, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF),
			1'b1, rsp_of(KIND_SUBSCRIBED, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1)});
		dir_tab.push_back('{req_of(CMD_UNSUBSCRIBE, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 31'd0),
			1'b0, '0});
		dir_tab.push_back('{req_of(CMD_PUBLISH, 3'd0, 32'h0, 16'h0, 31'd0), 1'b0, '0});
		dir_tab.push_back('{req_of(CMD_SUBSCRIBE, 3'd5, 32'hC0A8_0001, 16'h0050, 31'd1000), 1'b1,
			rsp_of(KIND_SUBSCRIBED, 3'd5, 32'hC0A8_0001, 16'h0050, 1'b1)});
		dir_tab.push_back('{req_of(CMD_SUBSCRIBE, 3'd5, 32'hC0A8_0001, 16'h0051, 31'd1000), 1'b1,
			rsp_of(KIND_SUBSCRIBED, 3'd5, 32'hC0A8_0001, 16'h0051, 1'b1)});
		dir_tab.push_back('{req_of(CMD_SUBSCRIBE, 3'd4, 32'hC0A8_0001, 16'h0050, 31'd1000), 1'b1,
			rsp_of(KIND_SUBSCRIBED, 3'd4, 32'hC0A8_0001, 16'h0050, 1'b1)});
		dir_tab.push_back('{req_of(CMD_SUBSCRIBE, 3'd5, 32'hC0A8_0002, 16'h0050, 31'd1000), 1'b1,
			rsp_of(KIND_SUBSCRIBED, 3'd5, 32'hC0A8_0002, 16'h0050, 1'b1)});
		dir_tab.push_back('{req_of(CMD_SUBSCRIBE, 3'd5, 32'hC0A8_0001, 16'h0050, 31'd1000), 1'b1,
			rsp_of(KIND_SUBSCRIBED, 3'd5, 32'hC0A8_0001, 16'h0050, 1'b1)});
		dir_tab.push_back('{req_of(CMD_PUBLISH, 3'd0, 32'h0, 16'h0, 31'd2000), 1'b0, '0});
		dir_tab.push_back('{req_of(CMD_UNSUBSCRIBE, 3'd5, 32'hC0A8_0001, 16'h0051, 31'd2000),
			1'b0, '0});
		dir_tab.push_back('{req_of(CMD_PUBLISH, 3'd0, 32'h0, 16'h0, 31'd61000), 1'b0, '0});
		dir_tab.push_back('{req_of(CMD_PUBLISH, 3'd0, 32'h0, 16'h0, 31'd61001), 1'b0, '0});

		for (i = 0; i < POOL; i++) begin
			if (i >= 14) begin
				pool[i] = pool[i - 14];
				case (i % 3)
					0: pool[i].port[0] = ~pool[i].port[0];
					1: pool[i].addr_type[0] = ~pool[i].addr_type[0];
					default: pool[i].ip[0] = ~pool[i].ip[0];
				endcase
			end else begin
				pool[i].addr_type = 3'($urandom);
				pool[i].ip        = $urandom;
				pool[i].port      = 16'($urandom);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < dir_tab.size(); i++) begin
			offer(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);
		end

		write_ttl(17'd0);
		run_random(PHASE_ITEMS, 2, 0);
		write_ttl(17'd86400);
		run_random(PHASE_ITEMS, 50000000, 1);
		write_ttl(17'($urandom_range(1, 86400)));
		run_random(PHASE_ITEMS, int'(ttl_s) * 166 + 1, 2);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
